[rtl/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg: shared types, constants and helpers for the smeared charge core
// Atom table layout, per-item tags, pipeline sideband records, Q28 multiply.
// ----------------------------------------------------------------------------
package scp_pkg;

    // atom table
    localparam int MAX_ATOMS = 64;
    localparam int SLOT_W    = $clog2(MAX_ATOMS);
    localparam int COUNT_W   = SLOT_W + 1;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // fixed point
    localparam int QF = 28;
    localparam int POT_W = 48;
    localparam int ACC_W = POT_W + SLOT_W;

    // square root pipeline: two result bits per stage
    localparam int SQ_PER    = 2;
    localparam int SQ_STAGES = 32 / SQ_PER;

    // divider pipeline: 64-bit dividend, quotient known to fit 57 bits
    localparam int DIV_N_W    = 64;
    localparam int DIV_D_W    = 38;
    localparam int DIV_R_W    = DIV_D_W + 1;
    localparam int DIV_Q_W    = 57;
    localparam int DIV_PER    = 3;
    localparam int DIV_STAGES = DIV_Q_W / DIV_PER;

    typedef logic signed [35:0] q_t;

    localparam longint Q1L  = 64'sd1 <<< QF;
    localparam q_t     Q_12 = q_t'(12 * Q1L);
    localparam q_t     Q_14 = q_t'(14 * Q1L);
    localparam q_t     Q_28 = q_t'(28 * Q1L);
    localparam q_t     Q_30 = q_t'(30 * Q1L);

    localparam logic signed [POT_W-1:0] POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
    localparam logic signed [POT_W-1:0] POT_MIN = {1'b1, {(POT_W-1){1'b0}}};
    localparam logic [DIV_Q_W-1:0] Q_POS_LIM = DIV_Q_W'({(POT_W-1){1'b1}});
    localparam logic [DIV_Q_W-1:0] Q_NEG_LIM = DIV_Q_W'(1) << (POT_W-1);

    typedef struct packed {
        logic first;
        logic last;
        logic empty;
        logic batch_end;
    } scp_tag_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] charge;
        logic [30:0]        radius;
    } scp_atom_t;

    // sideband through the square root
    typedef struct packed {
        scp_tag_t           tag;
        logic signed [31:0] charge;
        logic [30:0]        radius;
        logic               sh;
    } scp_sqside_t;

    // sideband through the dividers and polynomial
    typedef struct packed {
        scp_tag_t           tag;
        logic signed [31:0] charge;
        logic [30:0]        rcx;
        logic [32:0]        r;
        logic               outside;
    } scp_dside_t;

    // Q28 product, rounded half away from zero
    function automatic q_t mulq(q_t a, q_t b);
        logic [35:0] ma;
        logic [35:0] mb;
        logic [71:0] prod;
        logic [71:0] rnd;
        ma   = a[35] ? 36'(-a) : 36'(a);
        mb   = b[35] ? 36'(-b) : 36'(b);
        prod = ma * mb;
        rnd  = (prod + (72'd1 << (QF-1))) >> QF;
        mulq = (a[35] ^ b[35]) ? -q_t'(rnd[35:0]) : q_t'(rnd[35:0]);
    endfunction

endpackage

[rtl/scp_isqrt.sv]
// ----------------------------------------------------------------------------
// scp_isqrt: pipelined integer square root
// floor(sqrt(s)) of a 64-bit value, two root bits per register stage.
// ----------------------------------------------------------------------------
module scp_isqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [63:0]         in_s,
    input  scp_pkg::scp_sqside_t in_side,
    output logic                out_valid,
    output logic [31:0]         out_root,
    output scp_pkg::scp_sqside_t out_side
);
    import scp_pkg::*;

    logic        v_reg    [SQ_STAGES];
    logic [34:0] rem_reg  [SQ_STAGES];
    logic [34:0] rem_next [SQ_STAGES];
    logic [31:0] root_reg [SQ_STAGES];
    logic [31:0] root_next[SQ_STAGES];
    logic [63:0] s_reg    [SQ_STAGES];
    logic [63:0] s_next   [SQ_STAGES];
    scp_sqside_t side_reg [SQ_STAGES];

    genvar g;
    generate
        for (g = 0; g < SQ_STAGES; g++)
        begin : g_stage
            logic        p_v;
            logic [34:0] p_rem;
            logic [31:0] p_root;
            logic [63:0] p_s;
            scp_sqside_t p_side;

            if (g == 0)
            begin : g_head
                assign p_v    = in_valid;
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_s    = in_s;
                assign p_side = in_side;
            end
            else
            begin : g_body
                assign p_v    = v_reg[g-1];
                assign p_rem  = rem_reg[g-1];
                assign p_root = root_reg[g-1];
                assign p_s    = s_reg[g-1];
                assign p_side = side_reg[g-1];
            end

            // digit-by-digit root, one bit per step
            always_comb
            begin : c_step
                logic [34:0] rem;
                logic [34:0] trial;
                logic [31:0] root;
                logic [63:0] s;
                rem  = p_rem;
                root = p_root;
                s    = p_s;
                for (int k = 0; k < SQ_PER; k++)
                begin
                    rem   = {rem[32:0], s[63:62]};
                    s     = {s[61:0], 2'b00};
                    trial = {1'b0, root, 2'b01};
                    if (rem >= trial)
                    begin
                        rem  = rem - trial;
                        root = {root[30:0], 1'b1};
                    end
                    else
                    begin
                        root = {root[30:0], 1'b0};
                    end
                end
                rem_next[g]  = rem;
                root_next[g] = root;
                s_next[g]    = s;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[g] <= 1'b0;
                else if (adv)
                    v_reg[g] <= p_v;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[g]  <= rem_next[g];
                    root_reg[g] <= root_next[g];
                    s_reg[g]    <= s_next[g];
                    side_reg[g] <= p_side;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[SQ_STAGES-1];
    assign out_root  = root_reg[SQ_STAGES-1];
    assign out_side  = side_reg[SQ_STAGES-1];

endmodule

[rtl/scp_div.sv]
// ----------------------------------------------------------------------------
// scp_div: pipelined restoring divider
// 64-bit dividend by 38-bit divisor, quotient below 2^57, three bits a stage.
// ----------------------------------------------------------------------------
module scp_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             in_valid,
    input  logic [scp_pkg::DIV_N_W-1:0]      in_num,
    input  logic [scp_pkg::DIV_D_W-1:0]      in_den,
    input  scp_pkg::scp_dside_t              in_side,
    output logic                             out_valid,
    output logic [scp_pkg::DIV_Q_W-1:0]      out_q,
    output scp_pkg::scp_dside_t              out_side
);
    import scp_pkg::*;

    localparam int HEAD_W = DIV_N_W - DIV_Q_W;

    logic               v_reg   [DIV_STAGES];
    logic [DIV_R_W-1:0] rem_reg [DIV_STAGES];
    logic [DIV_R_W-1:0] rem_next[DIV_STAGES];
    logic [DIV_Q_W-1:0] n_reg   [DIV_STAGES];
    logic [DIV_Q_W-1:0] n_next  [DIV_STAGES];
    logic [DIV_Q_W-1:0] q_reg   [DIV_STAGES];
    logic [DIV_Q_W-1:0] q_next  [DIV_STAGES];
    logic [DIV_D_W-1:0] den_reg [DIV_STAGES];
    scp_dside_t         side_reg[DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_stage
            logic               p_v;
            logic [DIV_R_W-1:0] p_rem;
            logic [DIV_Q_W-1:0] p_n;
            logic [DIV_Q_W-1:0] p_q;
            logic [DIV_D_W-1:0] p_den;
            scp_dside_t         p_side;

            if (g == 0)
            begin : g_head
                // top bits of the dividend are already below the divisor
                assign p_v    = in_valid;
                assign p_rem  = DIV_R_W'(in_num[DIV_N_W-1 -: HEAD_W]);
                assign p_n    = in_num[DIV_Q_W-1:0];
                assign p_q    = '0;
                assign p_den  = in_den;
                assign p_side = in_side;
            end
            else
            begin : g_body
                assign p_v    = v_reg[g-1];
                assign p_rem  = rem_reg[g-1];
                assign p_n    = n_reg[g-1];
                assign p_q    = q_reg[g-1];
                assign p_den  = den_reg[g-1];
                assign p_side = side_reg[g-1];
            end

            // shift in one dividend bit, subtract if it fits
            always_comb
            begin : c_step
                logic [DIV_R_W-1:0] rem;
                logic [DIV_Q_W-1:0] n;
                logic [DIV_Q_W-1:0] q;
                rem = p_rem;
                n   = p_n;
                q   = p_q;
                for (int k = 0; k < DIV_PER; k++)
                begin
                    rem = {rem[DIV_R_W-2:0], n[DIV_Q_W-1]};
                    n   = {n[DIV_Q_W-2:0], 1'b0};
                    if (rem >= {1'b0, p_den})
                    begin
                        rem = rem - {1'b0, p_den};
                        q   = {q[DIV_Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q   = {q[DIV_Q_W-2:0], 1'b0};
                    end
                end
                rem_next[g] = rem;
                n_next[g]   = n;
                q_next[g]   = q;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[g] <= 1'b0;
                else if (adv)
                    v_reg[g] <= p_v;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[g]  <= rem_next[g];
                    n_reg[g]    <= n_next[g];
                    q_reg[g]    <= q_next[g];
                    den_reg[g]  <= p_den;
                    side_reg[g] <= p_side;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_q     = q_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

[rtl/scp_term.sv]
// ----------------------------------------------------------------------------
// scp_term: per-atom potential term pipeline
// Distance, square root, outside/inside select, smoothing polynomial, divide
// and clip to the 48-bit range. One atom may enter every cycle with adv high.
// ----------------------------------------------------------------------------
module scp_term (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  scp_pkg::scp_tag_t        in_tag,
    input  logic signed [31:0]       in_pt_x,
    input  logic signed [31:0]       in_pt_y,
    input  logic signed [31:0]       in_pt_z,
    input  scp_pkg::scp_atom_t       in_atom,
    output logic                     out_valid,
    output scp_pkg::scp_tag_t        out_tag,
    output logic signed [47:0]       out_term,
    output logic                     out_sat
);
    import scp_pkg::*;

    // ---------------- stage 1: axis differences ----------------
    logic        s1_v_reg;
    logic [31:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic [31:0] s1_dx_next, s1_dy_next, s1_dz_next;
    scp_sqside_t s1_side_reg, s1_side_next;

    always_comb
    begin : c_s1
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        dx = 33'(in_pt_x) - 33'(in_atom.x);
        dy = 33'(in_pt_y) - 33'(in_atom.y);
        dz = 33'(in_pt_z) - 33'(in_atom.z);
        s1_dx_next = dx[32] ? 32'(-dx) : 32'(dx);
        s1_dy_next = dy[32] ? 32'(-dy) : 32'(dy);
        s1_dz_next = dz[32] ? 32'(-dz) : 32'(dz);
        s1_side_next.tag    = in_tag;
        s1_side_next.charge = in_atom.charge;
        s1_side_next.radius = in_atom.radius;
        // halve every axis when one would overflow the square
        s1_side_next.sh     = s1_dx_next[31] | s1_dy_next[31] | s1_dz_next[31];
    end

    // ---------------- stage 2: squares ----------------
    logic        s2_v_reg;
    logic [61:0] s2_sx_reg, s2_sy_reg, s2_sz_reg;
    logic [61:0] s2_sx_next, s2_sy_next, s2_sz_next;
    scp_sqside_t s2_side_reg;

    always_comb
    begin : c_s2
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
        ex = s1_dx_reg >> s1_side_reg.sh;
        ey = s1_dy_reg >> s1_side_reg.sh;
        ez = s1_dz_reg >> s1_side_reg.sh;
        s2_sx_next = ex[30:0] * ex[30:0];
        s2_sy_next = ey[30:0] * ey[30:0];
        s2_sz_next = ez[30:0] * ez[30:0];
    end

    // ---------------- stage 3: sum of squares ----------------
    logic        s3_v_reg;
    logic [63:0] s3_s_reg, s3_s_next;
    scp_sqside_t s3_side_reg;

    assign s3_s_next = 64'(s2_sx_reg) + 64'(s2_sy_reg) + 64'(s2_sz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;
            s1_dz_reg   <= s1_dz_next;
            s1_side_reg <= s1_side_next;
            s2_sx_reg   <= s2_sx_next;
            s2_sy_reg   <= s2_sy_next;
            s2_sz_reg   <= s2_sz_next;
            s2_side_reg <= s1_side_reg;
            s3_s_reg    <= s3_s_next;
            s3_side_reg <= s2_side_reg;
        end
    end

    // ---------------- distance ----------------
    logic        sq_v;
    logic [31:0] sq_root;
    scp_sqside_t sq_side;

    scp_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_v_reg),
        .in_s      (s3_s_reg),
        .in_side   (s3_side_reg),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // ---------------- stage D: region select ----------------
    logic       sd_v_reg;
    scp_dside_t sd_side_reg, sd_side_next;

    always_comb
    begin
        sd_side_next.tag     = sq_side.tag;
        sd_side_next.charge  = sq_side.charge;
        sd_side_next.rcx     = (sq_side.radius == '0) ? 31'd1 : sq_side.radius;
        sd_side_next.r       = sq_side.sh ? {sq_root, 1'b0} : {1'b0, sq_root};
        sd_side_next.outside = sd_side_next.r > {2'b00, sd_side_next.rcx};
    end

    // u = r / rc in Q28 (only meaningful inside the radius)
    logic               u_v;
    logic [DIV_Q_W-1:0] u_q;
    scp_dside_t         u_side;

    scp_div u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sd_v_reg),
        .in_num    ({5'b0, sd_side_reg.r[30:0], 28'b0}),
        .in_den    ({7'b0, sd_side_reg.rcx}),
        .in_side   (sd_side_reg),
        .out_valid (u_v),
        .out_q     (u_q),
        .out_side  (u_side)
    );

    // ---------------- polynomial stages ----------------
    logic       p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg, p6_v_reg;
    scp_dside_t p1_side_reg, p2_side_reg, p3_side_reg, p4_side_reg;
    scp_dside_t p5_side_reg, p6_side_reg;
    q_t         p1_u_reg, p1_a_reg, p1_u2_reg;
    q_t         p1_u_next, p1_a_next, p1_u2_next;
    q_t         p2_b_reg, p2_u3_reg, p2_u2_reg;
    q_t         p2_b_next, p2_u3_next;
    q_t         p3_c_reg, p3_u2_reg, p3_c_next;
    logic [31:0] p4_p_reg, p4_p_next;
    logic [31:0] p5_cm_reg, p5_cm_next;
    logic [63:0] p5_prod_reg, p5_prod_next;
    logic [DIV_N_W-1:0] p6_num_reg, p6_num_next;
    logic [DIV_D_W-1:0] p6_den_reg, p6_den_next;

    // P1: a = 9u - 30, u^2
    always_comb
    begin
        p1_u_next  = q_t'({7'b0, u_q[28:0]});
        p1_a_next  = (p1_u_next <<< 3) + p1_u_next - Q_30;
        p1_u2_next = mulq(p1_u_next, p1_u_next);
    end

    // P2: b = 28 + u*a, u^3
    always_comb
    begin
        p2_b_next  = Q_28 + mulq(p1_u_reg, p1_a_reg);
        p2_u3_next = mulq(p1_u2_reg, p1_u_reg);
    end

    // P3: c = -14 + u^3*b
    assign p3_c_next = mulq(p2_u3_reg, p2_b_reg) - Q_14;

    // P4: p = 12 + u^2*c, clamped to [0, 12]
    always_comb
    begin : c_p4
        q_t p;
        p = Q_12 + mulq(p3_u2_reg, p3_c_reg);
        if (p < 0)
            p = '0;
        else if (p > Q_12)
            p = Q_12;
        p4_p_next = p[31:0];
    end

    // P5: charge magnitude times polynomial
    always_comb
    begin
        p5_cm_next   = p4_side_reg.charge[31] ? 32'(-p4_side_reg.charge)
                                              : 32'(p4_side_reg.charge);
        p5_prod_next = p5_cm_next * p4_p_reg;
    end

    // P6: pick dividend/divisor, add half divisor for rounding
    always_comb
    begin
        if (p5_side_reg.outside)
        begin
            p6_den_next = {5'b0, p5_side_reg.r};
            p6_num_next = {8'b0, p5_cm_reg, 24'b0} + DIV_N_W'(p5_side_reg.r[32:1]);
        end
        else
        begin
            p6_den_next = (DIV_D_W'(p5_side_reg.rcx) << 6)
                        + (DIV_D_W'(p5_side_reg.rcx) << 4);
            p6_num_next = p5_prod_reg + DIV_N_W'(p6_den_next[DIV_D_W-1:1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_v_reg <= 1'b0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
            p6_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            sd_v_reg <= sq_v;
            p1_v_reg <= u_v;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
            p6_v_reg <= p5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_side_reg <= sd_side_next;
            p1_side_reg <= u_side;
            p1_u_reg    <= p1_u_next;
            p1_a_reg    <= p1_a_next;
            p1_u2_reg   <= p1_u2_next;
            p2_side_reg <= p1_side_reg;
            p2_b_reg    <= p2_b_next;
            p2_u3_reg   <= p2_u3_next;
            p2_u2_reg   <= p1_u2_reg;
            p3_side_reg <= p2_side_reg;
            p3_c_reg    <= p3_c_next;
            p3_u2_reg   <= p2_u2_reg;
            p4_side_reg <= p3_side_reg;
            p4_p_reg    <= p4_p_next;
            p5_side_reg <= p4_side_reg;
            p5_cm_reg   <= p5_cm_next;
            p5_prod_reg <= p5_prod_next;
            p6_side_reg <= p5_side_reg;
            p6_num_reg  <= p6_num_next;
            p6_den_reg  <= p6_den_next;
        end
    end

    // ---------------- final divide ----------------
    logic               dv_v;
    logic [DIV_Q_W-1:0] dv_q;
    scp_dside_t         dv_side;

    scp_div u_div_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p6_v_reg),
        .in_num    (p6_num_reg),
        .in_den    (p6_den_reg),
        .in_side   (p6_side_reg),
        .out_valid (dv_v),
        .out_q     (dv_q),
        .out_side  (dv_side)
    );

    // ---------------- clip to 48 bits ----------------
    logic                    ck_v_reg;
    scp_tag_t                ck_tag_reg;
    logic signed [POT_W-1:0] ck_term_reg, ck_term_next;
    logic                    ck_sat_reg, ck_sat_next;

    always_comb
    begin
        ck_sat_next = 1'b0;
        if (dv_side.charge[31])
        begin
            if (dv_q > Q_NEG_LIM)
            begin
                ck_term_next = POT_MIN;
                ck_sat_next  = 1'b1;
            end
            else
                ck_term_next = -POT_W'(dv_q[POT_W-1:0]);
        end
        else
        begin
            if (dv_q > Q_POS_LIM)
            begin
                ck_term_next = POT_MAX;
                ck_sat_next  = 1'b1;
            end
            else
                ck_term_next = POT_W'(dv_q[POT_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ck_v_reg <= 1'b0;
        else if (adv)
            ck_v_reg <= dv_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ck_tag_reg  <= dv_side.tag;
            ck_term_reg <= ck_term_next;
            ck_sat_reg  <= ck_sat_next;
        end
    end

    assign out_valid = ck_v_reg;
    assign out_tag   = ck_tag_reg;
    assign out_term  = ck_term_reg;
    assign out_sat   = ck_sat_reg;

endmodule

[rtl/smeared_charge_potential_sum_core.sv]
// ----------------------------------------------------------------------------
// smeared_charge_potential_sum_core: smeared nuclear charge potential summer
// Atom table, per-point atom sequencer, term pipeline and saturating adder.
// ----------------------------------------------------------------------------
// A load request writes one atom table entry. An evaluate request walks the
// first atoms_in_use table entries (capped at 64), one atom per cycle from
// the single table read port while the result is not stalled, so it holds
// off the input until the last atom is issued. Each atom passes 66 register
// stages (table read, differences, squares, sum, square root 16, region
// select, two dividers 19 each, polynomial 6 and clipping) before the result
// register. A stalled result freezes the whole pipeline and the input.
// ----------------------------------------------------------------------------
module smeared_charge_potential_sum_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         kind,
    input  logic [scp_pkg::SLOT_W-1:0]   atom_slot,
    input  logic signed [31:0]           pos_x,
    input  logic signed [31:0]           pos_y,
    input  logic signed [31:0]           pos_z,
    input  logic signed [31:0]           atom_charge,
    input  logic [30:0]                  smear_radius,
    input  logic                         last_point,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [47:0]           potential,
    output logic                         saturated,
    output logic                         batch_end,
    // configuration
    input  logic                         cfg_we,
    input  logic [scp_pkg::COUNT_W-1:0]  cfg_wdata
);
    import scp_pkg::*;

    logic adv;
    logic in_acc;

    // ---------------- configuration ----------------
    logic [COUNT_W-1:0] cfg_reg;
    logic [COUNT_W-1:0] n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
            cfg_reg <= cfg_wdata;
    end

    assign n_eff = (cfg_reg > COUNT_W'(MAX_ATOMS)) ? COUNT_W'(MAX_ATOMS) : cfg_reg;

    // ---------------- handshake ----------------
    logic out_valid_reg;
    logic busy_reg, busy_next;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = busy_reg || !adv;
    assign in_acc   = in_valid && !in_stall;

    // ---------------- atom sequencer ----------------
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [COUNT_W-1:0] n_reg;
    logic signed [31:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic               be_reg;
    logic               tok_last;

    assign tok_last = (n_reg == '0) || ((COUNT_W'(idx_reg) + COUNT_W'(1)) == n_reg);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (busy_reg && adv)
        begin
            idx_next = idx_reg + SLOT_W'(1);
            if (tok_last)
                busy_next = 1'b0;
        end
        else if (in_acc && kind == KIND_EVAL)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // point and batch mark held for the walk
    always_ff @(posedge clk)
    begin
        if (in_acc && kind == KIND_EVAL)
        begin
            n_reg    <= n_eff;
            pt_x_reg <= pos_x;
            pt_y_reg <= pos_y;
            pt_z_reg <= pos_z;
            be_reg   <= last_point;
        end
    end

    // ---------------- atom table ----------------
    scp_atom_t atom_mem [MAX_ATOMS];

    logic               s0_v_reg;
    scp_tag_t           s0_tag_reg;
    scp_atom_t          s0_atom_reg;
    logic signed [31:0] s0_x_reg, s0_y_reg, s0_z_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc && kind == KIND_LOAD)
            atom_mem[atom_slot] <= {pos_x, pos_y, pos_z, atom_charge, smear_radius};
        if (adv && busy_reg)
        begin
            s0_atom_reg          <= atom_mem[idx_reg];
            s0_x_reg             <= pt_x_reg;
            s0_y_reg             <= pt_y_reg;
            s0_z_reg             <= pt_z_reg;
            s0_tag_reg.first     <= (idx_reg == '0);
            s0_tag_reg.last      <= tok_last;
            s0_tag_reg.empty     <= (n_reg == '0);
            s0_tag_reg.batch_end <= be_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (adv)
            s0_v_reg <= busy_reg;
    end

    // ---------------- term pipeline ----------------
    logic                    t_valid;
    scp_tag_t                t_tag;
    logic signed [POT_W-1:0] t_term;
    logic                    t_sat;

    scp_term u_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s0_v_reg),
        .in_tag    (s0_tag_reg),
        .in_pt_x   (s0_x_reg),
        .in_pt_y   (s0_y_reg),
        .in_pt_z   (s0_z_reg),
        .in_atom   (s0_atom_reg),
        .out_valid (t_valid),
        .out_tag   (t_tag),
        .out_term  (t_term),
        .out_sat   (t_sat)
    );

    // ---------------- accumulator ----------------
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    acc_sat_reg, acc_sat_next;
    logic signed [POT_W-1:0] pot_next;
    logic                    sat_next;

    always_comb
    begin
        acc_next     = (t_tag.first ? '0 : acc_reg)
                     + (t_tag.empty ? '0 : ACC_W'(t_term));
        acc_sat_next = (t_tag.first ? 1'b0 : acc_sat_reg) | (t_sat & !t_tag.empty);
        sat_next     = acc_sat_next;
        if (acc_next > ACC_W'(POT_MAX))
        begin
            pot_next = POT_MAX;
            sat_next = 1'b1;
        end
        else if (acc_next < ACC_W'(POT_MIN))
        begin
            pot_next = POT_MIN;
            sat_next = 1'b1;
        end
        else
            pot_next = acc_next[POT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (t_valid && adv)
        begin
            acc_reg     <= acc_next;
            acc_sat_reg <= acc_sat_next;
        end
    end

    // ---------------- result register ----------------
    logic signed [POT_W-1:0] pot_reg;
    logic                    sat_reg;
    logic                    bend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (t_valid && adv && t_tag.last)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (t_valid && adv && t_tag.last)
        begin
            pot_reg  <= pot_next;
            sat_reg  <= sat_next;
            bend_reg <= t_tag.batch_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign potential = pot_reg;
    assign saturated = sat_reg;
    assign batch_end = bend_reg;

    // ---------------- checks ----------------
    a_eval_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind == KIND_EVAL) |=> busy_reg)
        else $error("evaluate request did not start the atom walk");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && n_reg != '0) |-> (COUNT_W'(idx_reg) < n_reg))
        else $error("atom index ran past the atom count");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(t_valid && t_tag.last))
        else $error("result raised without a closing term");

    a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> ($stable(t_valid) && $stable(s0_v_reg)))
        else $error("pipeline moved while the result was held");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the smeared charge potential summer
// Drives load and evaluate requests with random gaps and result stalls,
// predicts every potential in fixed point and compares each result in order.
// ----------------------------------------------------------------------------
module tb_top;
    import scp_pkg::*;

    localparam int  LATENCY   = 200;
    localparam int  WD_LIMIT  = 20000;
    localparam longint QONE   = 64'sd1 <<< 28;
    localparam longint PMAX   = (64'sd1 <<< 47) - 1;
    localparam longint PMIN   = -(64'sd1 <<< 47);

    typedef struct {
        logic               kind;
        logic [5:0]         slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] charge;
        logic [30:0]        radius;
        logic               last;
    } request_t;

    typedef struct {
        logic signed [47:0] potential;
        logic               saturated;
        logic               batch_end;
    } potential_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic kind = KIND_LOAD;
    logic [SLOT_W-1:0] atom_slot = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, atom_charge = '0;
    logic [30:0] smear_radius = '0;
    logic last_point = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [47:0] potential;
    logic saturated;
    logic batch_end;
    logic cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;

    // predictor state
    logic signed [31:0] atom_x[MAX_ATOMS], atom_y[MAX_ATOMS], atom_z[MAX_ATOMS];
    logic signed [31:0] atom_q[MAX_ATOMS];
    logic [30:0]        atom_rc[MAX_ATOMS];
    int                 atoms_used = 0;

    potential_t pending_potentials[$];
    int  mismatches = 0;
    bit  no_idle = 1'b0;
    int  holdoff_req = 0;
    int  holdoff_left = 0;
    int  quiet_cycles = 0;

    always #2 clk = ~clk;

    smeared_charge_potential_sum_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .atom_slot(atom_slot), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .atom_charge(atom_charge), .smear_radius(smear_radius),
        .last_point(last_point),
        .out_valid(out_valid), .out_stall(out_stall), .potential(potential),
        .saturated(saturated), .batch_end(batch_end),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // ---------------- potential predictor ----------------
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned rem, root, bitv;
        rem = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Q28 product, rounded half away from zero
    function automatic longint q28_mul(longint a, longint b);
        longint unsigned ma, mb, p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = (ma * mb + (64'd1 << 27)) >> 28;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint atom_potential(int idx, logic signed [31:0] px,
            logic signed [31:0] py, logic signed [31:0] pz, inout bit sat);
        longint diff[3];
        longint unsigned d[3], s, r, rc, num, den, m;
        longint u, a, b, u2, u3, c, p;
        bit sh, neg;
        diff[0] = longint'(px) - longint'(atom_x[idx]);
        diff[1] = longint'(py) - longint'(atom_y[idx]);
        diff[2] = longint'(pz) - longint'(atom_z[idx]);
        sh = 0;
        s = 0;
        for (int j = 0; j < 3; j++)
        begin
            d[j] = diff[j] < 0 ? -diff[j] : diff[j];
            if (d[j] >= (64'd1 << 31))
                sh = 1;
        end
        for (int j = 0; j < 3; j++)
            s += (d[j] >> sh) * (d[j] >> sh);
        r = floor_sqrt(s) << sh;
        rc = atom_rc[idx] == 0 ? 1 : atom_rc[idx];
        neg = atom_q[idx] < 0;
        m = neg ? -longint'(atom_q[idx]) : longint'(atom_q[idx]);
        if (r > rc)
        begin
            num = m << 24;
            den = r;
        end
        else
        begin
            // smooth polynomial inside the smearing radius
            u = longint'((r << 28) / rc);
            a = 9 * u - 30 * QONE;
            b = 28 * QONE + q28_mul(u, a);
            u2 = q28_mul(u, u);
            u3 = q28_mul(u2, u);
            c = -14 * QONE + q28_mul(u3, b);
            p = 12 * QONE + q28_mul(u2, c);
            if (p < 0)
                p = 0;
            if (p > 12 * QONE)
                p = 12 * QONE;
            num = m * longint'(p);
            den = 80 * rc;
        end
        m = (num + den / 2) / den;
        if (neg && m > (64'd1 << 47))
        begin
            sat = 1;
            return PMIN;
        end
        if (!neg && m > PMAX)
        begin
            sat = 1;
            return PMAX;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    task automatic predict(request_t rq);
        potential_t res;
        longint sum;
        bit sat;
        int n;
        if (rq.kind == KIND_LOAD)
        begin
            atom_x[rq.slot] = rq.x;
            atom_y[rq.slot] = rq.y;
            atom_z[rq.slot] = rq.z;
            atom_q[rq.slot] = rq.charge;
            atom_rc[rq.slot] = rq.radius;
            return;
        end
        n = atoms_used > MAX_ATOMS ? MAX_ATOMS : atoms_used;
        sum = 0;
        sat = 0;
        for (int i = 0; i < n; i++)
            sum += atom_potential(i, rq.x, rq.y, rq.z, sat);
        if (sum > PMAX)
        begin
            sum = PMAX;
            sat = 1;
        end
        if (sum < PMIN)
        begin
            sum = PMIN;
            sat = 1;
        end
        res.potential = sum[47:0];
        res.saturated = sat;
        res.batch_end = rq.last;
        pending_potentials.push_back(res);
    endtask

    // ---------------- request driver ----------------
    task automatic send_request(request_t rq);
        int gap;
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 26)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        kind = rq.kind;
        atom_slot = rq.slot;
        pos_x = rq.x;
        pos_y = rq.y;
        pos_z = rq.z;
        atom_charge = rq.charge;
        smear_radius = rq.radius;
        last_point = rq.last;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict(rq);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drain();
        drop_valid();
        while (pending_potentials.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_atoms_used(int n);
        wait_drain();
        repeat (LATENCY) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = n[COUNT_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        atoms_used = n;
    endtask

    function automatic request_t load_req(int slot, logic signed [31:0] x,
            logic signed [31:0] y, logic signed [31:0] z,
            logic signed [31:0] q, logic [30:0] rc);
        request_t rq;
        rq.kind = KIND_LOAD;
        rq.slot = slot[5:0];
        rq.x = x;
        rq.y = y;
        rq.z = z;
        rq.charge = q;
        rq.radius = rc;
        rq.last = 1'($urandom_range(1));
        return rq;
    endfunction

    function automatic request_t eval_req(logic signed [31:0] x,
            logic signed [31:0] y, logic signed [31:0] z, logic last);
        request_t rq;
        rq.kind = KIND_EVAL;
        rq.slot = 6'($urandom_range(63));
        rq.x = x;
        rq.y = y;
        rq.z = z;
        rq.charge = $urandom;
        rq.radius = 31'($urandom);
        rq.last = last;
        return rq;
    endfunction

    function automatic request_t random_load();
        logic [30:0] rc;
        logic signed [31:0] q;
        rc = $urandom_range(1) ? 31'($urandom_range(0, 1 << 20)) : 31'($urandom);
        q = $urandom_range(1) ? 32'($urandom) : 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        return load_req($urandom_range(63), $urandom, $urandom, $urandom, q, rc);
    endfunction

    function automatic request_t random_eval(int n);
        int s;
        if (n > 0 && $urandom_range(1))
        begin
            // land near an atom so the inside polynomial is exercised
            s = $urandom_range(0, (n > MAX_ATOMS ? MAX_ATOMS : n) - 1);
            return eval_req(atom_x[s] + int'($urandom_range(0, 1 << 18)) - (1 << 17),
                            atom_y[s] + int'($urandom_range(0, 1 << 18)) - (1 << 17),
                            atom_z[s] + int'($urandom_range(0, 1 << 18)) - (1 << 17),
                            1'($urandom_range(1)));
        end
        return eval_req($urandom, $urandom, $urandom, 1'($urandom_range(1)));
    endfunction

    // ---------------- result side ----------------
    always @(negedge clk)
    begin
        if (holdoff_req > 0)
        begin
            holdoff_left = holdoff_req;
            holdoff_req = 0;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 26);
    end

    always @(posedge clk)
    begin
        potential_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_potentials.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: potential %h", potential);
            end
            else
            begin
                exp_res = pending_potentials.pop_front();
                if (potential !== exp_res.potential || saturated !== exp_res.saturated ||
                    batch_end !== exp_res.batch_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp pot %h sat %b end %b, got pot %h sat %b end %b",
                                 exp_res.potential, exp_res.saturated, exp_res.batch_end,
                                 potential, saturated, batch_end);
                end
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_no_atoms();
        send_request(eval_req(32'sh7fffffff, 32'sh80000000, 0, 1'b1));
        send_request(eval_req(0, 0, 0, 1'b0));
    endtask

    task automatic test_fill_table();
        for (int i = 0; i < MAX_ATOMS; i++)
            send_request(random_load());
    endtask

    task automatic test_single_atom();
        set_atoms_used(1);
        send_request(load_req(0, 0, 0, 0, 32'sd65536, 31'd65536));
        send_request(eval_req(0, 0, 0, 1'b0));                 // center
        send_request(eval_req(32'sd32768, 0, 0, 1'b0));        // half radius
        send_request(eval_req(0, 32'sd65536, 0, 1'b0));        // on the radius
        send_request(eval_req(0, 0, 32'sd65537, 1'b1));        // just outside
        send_request(eval_req(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1));
        // widest separation, forces the halved distance path
        send_request(load_req(0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                              32'sh80000000, 31'h7fffffff));
        send_request(eval_req(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0));
        send_request(eval_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1));
        // zero radius treated as one LSB, term clips
        send_request(load_req(0, 0, 0, 0, 32'sh7fffffff, 31'd0));
        send_request(eval_req(1, 0, 0, 1'b0));
        send_request(eval_req(0, 0, 0, 1'b0));
        send_request(load_req(0, 0, 0, 0, 32'sh80000000, 31'd0));
        send_request(eval_req(0, 0, 1, 1'b1));
    endtask

    task automatic test_sum_clip();
        set_atoms_used(0);
        for (int i = 0; i < MAX_ATOMS; i++)
            send_request(load_req(i, 0, 0, 0, 32'sh40000000, 31'd1));
        set_atoms_used(127);   // above the table size, caps at 64
        send_request(eval_req(0, 0, 1, 1'b1));
        set_atoms_used(64);
        send_request(eval_req(0, 2, 0, 1'b0));
    endtask

    task automatic test_random();
        int sizes[6] = '{1, 3, 8, 64, 100, 0};
        request_t rq;
        for (int ph = 0; ph < 6; ph++)
        begin
            set_atoms_used(ph == 5 ? $urandom_range(2, 20) : sizes[ph]);
            no_idle = (ph == 2);
            for (int k = 0; k < 205; k++)
            begin
                if ($urandom_range(99) < 25)
                    rq = random_load();
                else
                    rq = random_eval(atoms_used);
                send_request(rq);
            end
            no_idle = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        set_atoms_used(2);
        holdoff_req = 600;
        for (int k = 0; k < 25; k++)
            send_request(random_eval(atoms_used));
        wait_drain();
        for (int k = 0; k < 5; k++)
            send_request(random_eval(atoms_used));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_no_atoms();
        test_fill_table();
        test_single_atom();
        test_sum_clip();
        test_fill_table();
        test_random();
        test_backpressure();
        wait_drain();
        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0 && pending_potentials.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
